[rtl/plcar_pkg.sv]
// Package for the parallel load-cell reader: shared constants, codes and
// the control structs passed between the sequencer, lanes and output merge.
// No dependencies.
package plcar_pkg;

   localparam int CELL_COUNT_DEF = 8;
   localparam int MAX_CELLS      = 8;
   localparam int SAMPLE_W       = 24;
   localparam int TICK_W         = 17;
   localparam int PULSE_W        = 5;
   localparam int LIMIT_W        = 16;
   localparam int INDEX_W        = 3;

   localparam logic [PULSE_W-1:0] BITS_PER_CELL   = PULSE_W'(SAMPLE_W);
   localparam logic [TICK_W-1:0]  TICK_MAX        = {TICK_W{1'b1}};
   localparam logic [LIMIT_W-1:0] TIMEOUT_DEFAULT = LIMIT_W'(100);

   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_TICK     = 2'd1,
      OP_SNAPSHOT = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_SHIFT
   } phase_type;

   // Commands from the sequencer to every lane.
   typedef struct packed {
      logic clear;
      logic shift;
   } lane_ctl_type;

   // Events from the sequencer to the output merge.
   typedef struct packed {
      logic emit_values;
      logic emit_timeout;
   } emit_evt_type;

endpackage

[rtl/parallel_load_cell_adc_reader.sv]
// Top level of the parallel load-cell reader: sequencer, one shift lane per
// cell and the output merge. Depends on plcar_pkg and the plcar_* modules.
//
// Each input word is a start, a millisecond tick or a data line snapshot.
// The word that carries the gain-select snapshot starts a run of CELL_COUNT
// result words, one per cell, sent one a cycle from the output register as
// long as rsp_tready stays high; a timeout sends a single word instead.
// req_tready stays low while a run is being loaded into the output
// register, which the lanes share. Once the last word of a run sits in the
// output register, new input words are taken again while it waits.
module parallel_load_cell_adc_reader
   import plcar_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] cell_levels
   input  logic [1:0]         req_tuser,   // [1:0] op
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // [2:0] cell_index, [26:3] weight_raw, rest zero
   output logic               rsp_tuser,   // [0] status
   output logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   logic                accept;
   logic                busy;
   lane_ctl_type        lane_ctl;
   emit_evt_type        evt;
   logic [SAMPLE_W-1:0] samples [CELL_COUNT];
   logic [INDEX_W-1:0]  rsp_index;
   logic [SAMPLE_W-1:0] rsp_weight;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   plcar_ctrl #(.CELL_COUNT(CELL_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (op_type'(req_tuser)),
      .levels    (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .lane_ctl  (lane_ctl),
      .evt       (evt)
   );

   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_lane
      plcar_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .level  (req_tdata[c]),
         .sample (samples[c])
      );
   end

   plcar_merge #(.CELL_COUNT(CELL_COUNT)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .samples    (samples),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_index  (rsp_index),
      .rsp_weight (rsp_weight),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, rsp_weight, rsp_index};

endmodule

[rtl/plcar_lane.sv]
// One cell lane: a 24-bit shift register that takes its data line bit MSB
// first on every shift pulse. Depends on plcar_pkg.
module plcar_lane
   import plcar_pkg::*;
(
   input  logic                clock,
   input  lane_ctl_type        ctl,
   input  logic                level,
   output logic [SAMPLE_W-1:0] sample
);

   logic [SAMPLE_W-1:0] shift_ff;
   logic [SAMPLE_W-1:0] shift_in;

   always_comb begin
      shift_in = shift_ff;
      if (ctl.clear) begin
         shift_in = '0;
      end else if (ctl.shift) begin
         shift_in = {shift_ff[SAMPLE_W-2:0], level};
      end
   end

   // The start command always clears, so this register needs no reset.
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign sample = shift_ff;

endmodule

[rtl/plcar_ctrl.sv]
// Read sequencer: phase state machine, millisecond wait counter with timeout,
// pulse counter and the timeout limit register. Depends on plcar_pkg.
module plcar_ctrl
   import plcar_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  op_type             op,
   input  logic [MAX_CELLS-1:0] levels,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   output lane_ctl_type       lane_ctl,
   output emit_evt_type       evt
);

   phase_type           phase_ff, phase_in;
   logic [TICK_W-1:0]   waited_ff, waited_in;
   logic [PULSE_W-1:0]  pulse_ff, pulse_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [TICK_W-1:0]   waited_inc;
   logic                all_ready;

   assign all_ready  = (levels[CELL_COUNT-1:0] == '0);
   assign waited_inc = (waited_ff < TICK_MAX) ? waited_ff + TICK_W'(1) : waited_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         waited_ff <= '0;
         pulse_ff  <= '0;
         limit_ff  <= TIMEOUT_DEFAULT;
      end else begin
         phase_ff  <= phase_in;
         waited_ff <= waited_in;
         pulse_ff  <= pulse_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      waited_in        = waited_ff;
      pulse_in         = pulse_ff;
      lane_ctl         = '0;
      evt              = '0;
      if (accept) begin
         unique case (op)
            OP_START: begin
               phase_in       = PH_WAIT;
               waited_in      = '0;
               pulse_in       = '0;
               lane_ctl.clear = 1'b1;
            end
            OP_TICK: begin
               if (phase_ff == PH_WAIT) begin
                  waited_in = waited_inc;
                  if (waited_inc > {1'b0, limit_ff}) begin
                     phase_in         = PH_IDLE;
                     evt.emit_timeout = 1'b1;
                  end
               end
            end
            OP_SNAPSHOT: begin
               if (phase_ff == PH_WAIT) begin
                  if (all_ready) begin
                     phase_in = PH_SHIFT;
                     pulse_in = '0;
                  end
               end else if (phase_ff == PH_SHIFT) begin
                  if (pulse_ff < BITS_PER_CELL) begin
                     lane_ctl.shift = 1'b1;
                     pulse_in       = pulse_ff + PULSE_W'(1);
                  end else begin
                     // The gain-select pulse: its sample is dropped.
                     phase_in        = PH_IDLE;
                     pulse_in        = '0;
                     evt.emit_values = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[rtl/plcar_merge.sv]
// Output merge: walks the lanes one cell per word, or sends the single
// timeout word, through a registered result stage. Depends on plcar_pkg.
module plcar_merge
   import plcar_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  emit_evt_type        evt,
   input  logic [SAMPLE_W-1:0] samples [CELL_COUNT],
   output logic                busy,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [INDEX_W-1:0]  rsp_index,
   output logic [SAMPLE_W-1:0] rsp_weight,
   output logic                rsp_status,
   output logic                rsp_last
);

   localparam int IW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(CELL_COUNT - 1);

   logic                active_ff, active_in;
   logic                tmo_ff, tmo_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [SAMPLE_W-1:0] weight_ff, weight_in;
   logic                status_ff, status_in;
   logic                last_ff, last_in;
   logic                load;

   assign load = active_ff && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         tmo_ff    <= 1'b0;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         tmo_ff    <= tmo_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff  <= index_in;
      weight_ff <= weight_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   always_comb begin
      active_in = active_ff;
      tmo_in    = tmo_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      index_in  = index_ff;
      weight_in = weight_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      // New events only arrive while no run is being loaded (req_tready is low while busy).
      if (evt.emit_values || evt.emit_timeout) begin
         active_in = 1'b1;
         tmo_in    = evt.emit_timeout;
         idx_in    = '0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (tmo_ff) begin
            index_in  = '0;
            weight_in = '0;
            status_in = 1'b1;
            last_in   = 1'b1;
            active_in = 1'b0;
         end else begin
            index_in  = INDEX_W'(idx_ff);
            weight_in = samples[idx_ff];
            status_in = 1'b0;
            last_in   = (idx_ff == LAST_IDX);
            if (idx_ff == LAST_IDX) begin
               active_in = 1'b0;
               idx_in    = '0;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
      end
   end

   assign busy       = active_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_index  = index_ff;
   assign rsp_weight = weight_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule
